// File: src/v3n_pkg.sv
package v3n_pkg;

	localparam int COMP_W    = 32;
	localparam int SUM_W     = 64;
	localparam int ROOT_W    = 32;
	localparam int UNIT_FRAC = 30;
	localparam int QUO_W     = UNIT_FRAC + 1;

	// Magnitude and sign of one component
	typedef struct packed {
		logic              neg;
		logic [COMP_W-1:0] mag;
	} v3n_comp_t;

endpackage

// File: src/v3n_square_lane.sv
module v3n_square_lane
	import v3n_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [COMP_W-1:0] comp,
	output v3n_comp_t                comp_s1,
	output logic [SUM_W-1:0]         sq_s1
);

	logic [COMP_W-1:0] mag;

	// Take the magnitude; the most negative value maps to 2^31 unchanged
	always_comb begin
		mag = comp[COMP_W-1] ? (~comp + 1'b1) : comp;
	end

	// Register the square
	always_ff @(posedge clk) begin
		if (en) begin
			comp_s1.neg <= comp[COMP_W-1];
			comp_s1.mag <= mag;
			sq_s1       <= SUM_W'(mag) * SUM_W'(mag);
		end
	end

endmodule

// File: src/v3n_sqrt.sv
module v3n_sqrt
	import v3n_pkg::*;
#(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SUM_W-1:0]  radicand,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output logic [SIDE_W-1:0] out_side
);

	localparam int REM_W = SUM_W + 2;

	logic              valid_s [0:ROOT_W];
	logic [REM_W-1:0]  rem_s   [0:ROOT_W];
	logic [ROOT_W-1:0] root_s  [0:ROOT_W];
	logic [SIDE_W-1:0] side_s  [0:ROOT_W];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = REM_W'(radicand);
	assign root_s[0]  = '0;
	assign side_s[0]  = in_side;

	// One root bit per stage, most significant first
	for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
		localparam int B = ROOT_W - 1 - g;
		logic [REM_W-1:0] trial;
		logic             take;

		always_comb begin
			trial = (REM_W'(root_s[g]) << (B + 1)) + (REM_W'(1) << (2 * B));
			take  = rem_s[g] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else if (en) begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= take ? rem_s[g] - trial : rem_s[g];
				root_s[g+1] <= take ? (root_s[g] | (ROOT_W'(1) << B)) : root_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_valid = valid_s[ROOT_W];
	assign root      = root_s[ROOT_W];
	assign out_side  = side_s[ROOT_W];

endmodule

// File: src/v3n_div_lane.sv
module v3n_div_lane
	import v3n_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [ROOT_W-1:0] divisor,
	input  v3n_comp_t         comp,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo,
	output logic              neg,
	output logic [ROOT_W-1:0] out_divisor
);

	logic              valid_s [0:QUO_W];
	logic [ROOT_W-1:0] rem_s   [0:QUO_W];
	logic [QUO_W-1:0]  quo_s   [0:QUO_W];
	logic [ROOT_W-1:0] dvs_s   [0:QUO_W];
	logic              neg_s   [0:QUO_W];

	// Dividend is mag * 2^30; its top part mag/2 is already below the divisor
	assign valid_s[0] = in_valid;
	assign rem_s[0]   = {1'b0, comp.mag[COMP_W-1:1]};
	assign quo_s[0]   = '0;
	assign dvs_s[0]   = divisor;
	assign neg_s[0]   = comp.neg;

	// One quotient bit per stage, restoring
	for (genvar g = 0; g < QUO_W; g++) begin : g_stage
		logic [ROOT_W:0] shifted;
		logic            take;

		always_comb begin
			shifted = {rem_s[g], (g == 0) ? comp.mag[0] : 1'b0};
			take    = shifted >= {1'b0, dvs_s[g]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else if (en) begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= take ? ROOT_W'(shifted - {1'b0, dvs_s[g]})
					: ROOT_W'(shifted);
				quo_s[g+1] <= {quo_s[g][QUO_W-2:0], take};
				dvs_s[g+1] <= dvs_s[g];
				neg_s[g+1] <= neg_s[g];
			end
		end
	end

	assign out_valid   = valid_s[QUO_W];
	assign quo         = quo_s[QUO_W];
	assign neg         = neg_s[QUO_W];
	assign out_divisor = dvs_s[QUO_W];

endmodule

// File: src/vector3_normalize_core.sv
// Normalizes one three-component vector per cycle: Q15.16 components in, a Q1.30 unit
// vector, the truncated Q16.16 length and a nonzero flag out. Results come out in input
// order. Each word passes through the register of per-component squares, the register of
// their sum, the square root pipeline (one root bit per stage), the three parallel
// divider lanes (one quotient bit per stage) and the output register. The whole pipeline
// advances together, so when the output word is held the input stalls too; otherwise a
// new word is taken every cycle. A zero vector gives all zeros.
module vector3_normalize_core
	import v3n_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // comp_x, comp_y, comp_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // unit_x, unit_y, unit_z, length
	output logic         m_tuser    // nonzero
);

	localparam int SIDE_W = 3 * $bits(v3n_comp_t);

	logic              adv;
	logic              valid_s1, valid_s2;
	v3n_comp_t         comp_s1 [0:2];
	logic [SUM_W-1:0]  sq_s1   [0:2];
	logic [SUM_W-1:0]  sum_s2;
	logic [SIDE_W-1:0] side_s2;
	logic              sq_valid;
	logic [ROOT_W-1:0] len;
	logic [SIDE_W-1:0] side_rt;
	logic              div_valid [0:2];
	logic [QUO_W-1:0]  quo       [0:2];
	logic              div_neg   [0:2];
	logic [ROOT_W-1:0] div_len   [0:2];
	logic [31:0]       unit      [0:2];
	logic              out_v_q;
	logic [127:0]      data_q;
	logic              nz_q;

	assign adv      = !out_v_q || m_tready;
	assign s_tready = adv;

	// Square each component
	for (genvar l = 0; l < 3; l++) begin : g_sq
		v3n_square_lane u_sq (
			.clk    (clk),
			.en     (adv),
			.comp   (s_tdata[l*COMP_W +: COMP_W]),
			.comp_s1(comp_s1[l]),
			.sq_s1  (sq_s1[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
		end
	end

	// Sum the squares
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			side_s2 <= {comp_s1[2], comp_s1[1], comp_s1[0]};
		end
	end

	v3n_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (valid_s2),
		.radicand (sum_s2),
		.in_side  (side_s2),
		.out_valid(sq_valid),
		.root     (len),
		.out_side (side_rt)
	);

	// Divide each magnitude by the length
	for (genvar l = 0; l < 3; l++) begin : g_div
		v3n_div_lane u_div (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (adv),
			.in_valid   (sq_valid),
			.divisor    (len),
			.comp       (side_rt[l*$bits(v3n_comp_t) +: $bits(v3n_comp_t)]),
			.out_valid  (div_valid[l]),
			.quo        (quo[l]),
			.neg        (div_neg[l]),
			.out_divisor(div_len[l])
		);

		always_comb begin
			unit[l] = div_neg[l] ? (32'd0 - 32'(quo[l])) : 32'(quo[l]);
		end
	end

	// Merge lanes: apply signs, zero out a zero-length vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= div_valid[0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (div_len[0] == '0) begin
				data_q <= '0;
				nz_q   <= 1'b0;
			end else begin
				data_q <= {div_len[0], unit[2], unit[1], unit[0]};
				nz_q   <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = data_q;
	assign m_tuser  = nz_q;

	logic unused_valid;
	assign unused_valid = div_valid[1] ^ div_valid[2] ^ (|div_len[1]) ^ (|div_len[2]);

endmodule

// File: src/v3n_checker.sv
module v3n_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [95:0]  s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic         m_tuser
);

	// Hold a stalled output word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word dropped or changed while stalled");

	// Zero vector gives an all-zero word
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 128'd0)
		else $error("zero vector word not cleared");

	// A normalized word carries a nonzero length
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[127:96] != 32'd0)
		else $error("normalized word with zero length");

	// Input is open whenever the output register is empty
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	logic unused_in;
	assign unused_in = s_tvalid ^ (|s_tdata);

endmodule

bind vector3_normalize_core v3n_checker u_v3n_checker (.*);
